// ----- rtl/core/pt_pkg.sv -----
// ---------------------------------------------------------------------------
// pt_pkg
// Shared types, codes and helpers of the tabulated pair force core.
// ---------------------------------------------------------------------------
`default_nettype none

package pt_pkg;

    // default table resolution
    localparam int RES_DEFAULT = 1024;
    // width of a table coordinate index (covers the full resolution range)
    localparam int M_W = 17;

    // input function codes
    localparam logic [1:0] FN_WRITE_E  = 2'd0;
    localparam logic [1:0] FN_WRITE_D  = 2'd1;
    localparam logic [1:0] FN_NEIGHBOR = 2'd2;

    // result status codes
    localparam logic [2:0] ST_APPLIED    = 3'd0;
    localparam logic [2:0] ST_TYPE_SKIP  = 3'd1;
    localparam logic [2:0] ST_BEYOND     = 3'd2;
    localparam logic [2:0] ST_ZERO_TABLE = 3'd3;
    localparam logic [2:0] ST_BAD_RADIUS = 3'd4;
    localparam logic [2:0] ST_WRITTEN    = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_CUTOFF  = 2'd0;
    localparam logic [1:0] CFG_SCALE   = 2'd1;
    localparam logic [1:0] CFG_PARTNER = 2'd2;
    localparam logic [1:0] CFG_MATCH   = 2'd3;

    typedef struct packed {
        logic [47:0] cutoff_sq;
        logic [31:0] index_scale;
        logic [7:0]  partner_type;
        logic        match_any;
    } cfg_t;

    // what the back end has to do with a queued beat
    typedef enum logic [1:0] {
        KIND_WRITE_E,
        KIND_WRITE_D,
        KIND_REPORT,
        KIND_APPLY
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [2:0]         status;
        logic [15:0]        index;
        logic [10:0]        waddr;
        logic signed [31:0] value;
        logic signed [23:0] dx;
        logic signed [23:0] dy;
        logic signed [23:0] dz;
        logic [M_W-1:0]     m;
        logic [15:0]        t;
        logic               last;
    } q_entry_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SQ,
        F_SUM,
        F_MUL,
        F_QCALC,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_READ,
        B_COEF,
        B_M1,
        B_M2,
        B_M3,
        B_V,
        B_FORCE,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        logic signed [35:0] c1;
        logic signed [35:0] c2;
        logic signed [35:0] c3;
    } coef_t;

    // catmull-rom coefficients from four neighbouring table words
    function automatic coef_t calc_coef(input logic signed [31:0] p0,
                                        input logic signed [31:0] p1,
                                        input logic signed [31:0] p2,
                                        input logic signed [31:0] p3);
        logic signed [35:0] e0;
        logic signed [35:0] e1;
        logic signed [35:0] e2;
        logic signed [35:0] e3;
        coef_t c;
        e0 = 36'(p0);
        e1 = 36'(p1);
        e2 = 36'(p2);
        e3 = 36'(p3);
        c.c1 = e2 - e0;
        c.c2 = 36'sd2 * e0 - 36'sd5 * e1 + 36'sd4 * e2 - e3;
        c.c3 = 36'sd3 * (e1 - e2) + e3 - e0;
        return c;
    endfunction

    // clamp to the signed 48 bit range
    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        logic signed [47:0] r;
        if (v[49:47] != 3'b000 && v[49:47] != 3'b111)
            r = v[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        else
            r = v[47:0];
        return r;
    endfunction

    // clamp to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v[47:31] != {17{1'b0}} && v[47:31] != {17{1'b1}})
            r = v[47] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pair_table_cubic_force_core.sv -----
// Path: an accepted beat passes through the front end, the queue and the back end into the result
// register; the front end takes a new beat only once it is back in idle, and an applied neighbour
// holds the back end while it reads the tables through one read port per table and
// interpolates serially.
// Reset: asynchronous, active low; clears control, configuration and running sums,
// tables are undefined until written.
// ---------------------------------------------------------------------------
// pair_table_cubic_force_core
// Tabulated pair potential force with catmull-rom interpolation, fixed point.
// ---------------------------------------------------------------------------
`default_nettype none

module pair_table_cubic_force_core #(
    parameter int RES = pt_pkg::RES_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [47:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         func,
    input  wire logic [10:0]        table_index,
    input  wire logic signed [31:0] table_value,
    input  wire logic signed [23:0] disp_x,
    input  wire logic signed [23:0] disp_y,
    input  wire logic signed [23:0] disp_z,
    input  wire logic [7:0]         neighbor_type,
    input  wire logic [15:0]        neighbor_index,
    input  wire logic               last_neighbor,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              status,
    output logic [15:0]             result_index,
    output logic signed [31:0]      force_x,
    output logic signed [31:0]      force_y,
    output logic signed [31:0]      force_z,
    output logic signed [47:0]      energy_total,
    output logic signed [47:0]      center_force_x,
    output logic signed [47:0]      center_force_y,
    output logic signed [47:0]      center_force_z,
    output logic                    result_last
);

    pt_pkg::cfg_t     cfg_reg;
    pt_pkg::q_entry_t push_entry;
    pt_pkg::q_entry_t head;
    logic             push_valid;
    logic             q_full;
    logic             q_valid;
    logic             pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pt_pkg::CFG_CUTOFF:  cfg_reg.cutoff_sq    <= cfg_data;
                pt_pkg::CFG_SCALE:   cfg_reg.index_scale  <= cfg_data[31:0];
                pt_pkg::CFG_PARTNER: cfg_reg.partner_type <= cfg_data[7:0];
                pt_pkg::CFG_MATCH:   cfg_reg.match_any    <= cfg_data[0];
                default:             cfg_reg              <= cfg_reg;
            endcase
        end
    end

    pt_front #(
        .RES (RES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .table_index    (table_index),
        .table_value    (table_value),
        .disp_x         (disp_x),
        .disp_y         (disp_y),
        .disp_z         (disp_z),
        .neighbor_type  (neighbor_type),
        .neighbor_index (neighbor_index),
        .last_neighbor  (last_neighbor),
        .push_valid     (push_valid),
        .q_full         (q_full),
        .push_entry     (push_entry)
    );

    pt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .q_full     (q_full),
        .q_valid    (q_valid),
        .pop        (pop),
        .head       (head)
    );

    pt_back #(
        .RES (RES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .result_index   (result_index),
        .force_x        (force_x),
        .force_y        (force_y),
        .force_z        (force_z),
        .energy_total   (energy_total),
        .center_force_x (center_force_x),
        .center_force_y (center_force_y),
        .center_force_z (center_force_z),
        .result_last    (result_last)
    );

    // only an applied neighbour carries a force
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != pt_pkg::ST_APPLIED
        |-> force_x == 32'sd0 && force_y == 32'sd0 && force_z == 32'sd0)
        else $error("force on a result that was not applied");

    // table write results never close a central atom
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pt_pkg::ST_WRITTEN |-> !result_last)
        else $error("table write marked as last neighbour");

    // the back end only pops a queue that holds an entry
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ----- rtl/core/pt_ram.sv -----
// ---------------------------------------------------------------------------
// pt_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module pt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1029
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pt_front.sv -----
// ---------------------------------------------------------------------------
// pt_front
// Accepts input beats, filters by type and cutoff, forms the table index.
// ---------------------------------------------------------------------------
`default_nettype none

module pt_front #(
    parameter int RES = pt_pkg::RES_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pt_pkg::cfg_t        cfg,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [1:0]          func,
    input  wire logic [10:0]         table_index,
    input  wire logic signed [31:0]  table_value,
    input  wire logic signed [23:0]  disp_x,
    input  wire logic signed [23:0]  disp_y,
    input  wire logic signed [23:0]  disp_z,
    input  wire logic [7:0]          neighbor_type,
    input  wire logic [15:0]         neighbor_index,
    input  wire logic                last_neighbor,
    output logic                     push_valid,
    input  wire logic                q_full,
    output pt_pkg::q_entry_t         push_entry
);

    pt_pkg::front_state_t state_reg, state_next;
    pt_pkg::q_entry_t     ent_reg, ent_next;
    logic [46:0]          sqx_reg, sqx_next;
    logic [46:0]          sqy_reg, sqy_next;
    logic [46:0]          sqz_reg, sqz_next;
    logic [47:0]          rsq_reg, rsq_next;
    logic [47:0]          ph_reg, ph_next;
    logic [47:0]          pll_reg, pll_next;
    logic [47:0]          plh_reg, plh_next;

    logic signed [47:0]   sq_x;
    logic signed [47:0]   sq_y;
    logic signed [47:0]   sq_z;
    logic [47:0]          rsq_sum;
    logic [63:0]          lo_prod;
    logic [48:0]          q_full_w;
    logic [32:0]          m_full;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pt_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        sqx_reg <= sqx_next;
        sqy_reg <= sqy_next;
        sqz_reg <= sqz_next;
        rsq_reg <= rsq_next;
        ph_reg  <= ph_next;
        pll_reg <= pll_next;
        plh_reg <= plh_next;
    end

    // datapath terms
    always_comb
    begin
        sq_x     = ent_reg.dx * ent_reg.dx;
        sq_y     = ent_reg.dy * ent_reg.dy;
        sq_z     = ent_reg.dz * ent_reg.dz;
        rsq_sum  = 48'(sqx_reg) + 48'(sqy_reg) + 48'(sqz_reg);
        lo_prod  = (64'(plh_reg) << 16) + 64'(pll_reg);
        q_full_w = 49'(ph_reg) + 49'(lo_prod[63:32]);
        m_full   = q_full_w[48:16];
    end

    // next state and outputs
    always_comb
    begin
        state_next = state_reg;
        ent_next   = ent_reg;
        sqx_next   = sqx_reg;
        sqy_next   = sqy_reg;
        sqz_next   = sqz_reg;
        rsq_next   = rsq_reg;
        ph_next    = ph_reg;
        pll_next   = pll_reg;
        plh_next   = plh_reg;
        in_stall   = (state_reg != pt_pkg::F_IDLE);
        push_valid = 1'b0;
        push_entry = ent_reg;

        case (state_reg)
            pt_pkg::F_IDLE:
            begin
                if (in_valid)
                begin
                    ent_next.kind   = pt_pkg::KIND_REPORT;
                    ent_next.status = pt_pkg::ST_APPLIED;
                    ent_next.index  = neighbor_index;
                    ent_next.waddr  = table_index;
                    ent_next.value  = table_value;
                    ent_next.dx     = disp_x;
                    ent_next.dy     = disp_y;
                    ent_next.dz     = disp_z;
                    ent_next.m      = '0;
                    ent_next.t      = '0;
                    ent_next.last   = last_neighbor;
                    case (func)
                        pt_pkg::FN_WRITE_E:
                        begin
                            ent_next.kind   = pt_pkg::KIND_WRITE_E;
                            ent_next.status = pt_pkg::ST_WRITTEN;
                            ent_next.index  = 16'(table_index);
                            ent_next.last   = 1'b0;
                            state_next      = pt_pkg::F_PUSH;
                        end
                        pt_pkg::FN_WRITE_D:
                        begin
                            ent_next.kind   = pt_pkg::KIND_WRITE_D;
                            ent_next.status = pt_pkg::ST_WRITTEN;
                            ent_next.index  = 16'(table_index);
                            ent_next.last   = 1'b0;
                            state_next      = pt_pkg::F_PUSH;
                        end
                        pt_pkg::FN_NEIGHBOR:
                        begin
                            if (!cfg.match_any && neighbor_type != cfg.partner_type)
                            begin
                                ent_next.status = pt_pkg::ST_TYPE_SKIP;
                                state_next      = pt_pkg::F_PUSH;
                            end
                            else
                            begin
                                state_next = pt_pkg::F_SQ;
                            end
                        end
                        default:
                        begin
                            // unused function code: beat dropped
                            state_next = pt_pkg::F_IDLE;
                        end
                    endcase
                end
            end

            pt_pkg::F_SQ:
            begin
                sqx_next   = sq_x[46:0];
                sqy_next   = sq_y[46:0];
                sqz_next   = sq_z[46:0];
                state_next = pt_pkg::F_SUM;
            end

            pt_pkg::F_SUM:
            begin
                // cutoff filter
                if (rsq_sum > cfg.cutoff_sq)
                begin
                    ent_next.status = pt_pkg::ST_BEYOND;
                    state_next      = pt_pkg::F_PUSH;
                end
                else
                begin
                    rsq_next   = rsq_sum;
                    state_next = pt_pkg::F_MUL;
                end
            end

            pt_pkg::F_MUL:
            begin
                // rsq times scale as three 16 by 32 partial products
                ph_next    = rsq_reg[47:32] * cfg.index_scale;
                pll_next   = rsq_reg[15:0] * cfg.index_scale;
                plh_next   = rsq_reg[31:16] * cfg.index_scale;
                state_next = pt_pkg::F_QCALC;
            end

            pt_pkg::F_QCALC:
            begin
                if (m_full == 33'd0 || m_full > 33'(RES))
                begin
                    ent_next.status = pt_pkg::ST_BAD_RADIUS;
                end
                else
                begin
                    ent_next.kind = pt_pkg::KIND_APPLY;
                    ent_next.m    = m_full[pt_pkg::M_W-1:0];
                    ent_next.t    = q_full_w[15:0];
                end
                state_next = pt_pkg::F_PUSH;
            end

            pt_pkg::F_PUSH:
            begin
                push_valid = 1'b1;
                if (!q_full)
                begin
                    state_next = pt_pkg::F_IDLE;
                end
            end

            default:
            begin
                state_next = pt_pkg::F_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/pt_queue.sv -----
// ---------------------------------------------------------------------------
// pt_queue
// Two-entry queue between the classifying front end and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module pt_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    input  wire pt_pkg::q_entry_t push_entry,
    output logic                  q_full,
    output logic                  q_valid,
    input  wire logic             pop,
    output pt_pkg::q_entry_t      head
);

    pt_pkg::q_entry_t slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // pointer and count update
    always_comb
    begin
        do_push     = push_valid && (count_reg != 2'd2);
        do_pop      = pop && (count_reg != 2'd0);
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign q_full  = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign head    = slot_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ----- rtl/core/pt_back.sv -----
// ---------------------------------------------------------------------------
// pt_back
// Table store, cubic interpolation, force and running sums, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module pt_back #(
    parameter int RES = pt_pkg::RES_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    input  wire pt_pkg::q_entry_t    head,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [2:0]               status,
    output logic [15:0]              result_index,
    output logic signed [31:0]       force_x,
    output logic signed [31:0]       force_y,
    output logic signed [31:0]       force_z,
    output logic signed [47:0]       energy_total,
    output logic signed [47:0]       center_force_x,
    output logic signed [47:0]       center_force_y,
    output logic signed [47:0]       center_force_z,
    output logic                     result_last
);

    localparam int TDEPTH = RES + 5;
    localparam int AW     = $clog2(TDEPTH);

    pt_pkg::back_state_t state_reg, state_next;
    pt_pkg::q_entry_t    cur_reg, cur_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic [2:0]          stat_reg, stat_next;
    logic                acc_reg, acc_next;
    logic signed [31:0]  p_reg [2][4];
    logic signed [31:0]  p_next [2][4];
    logic signed [35:0]  c1_reg [2];
    logic signed [35:0]  c1_next [2];
    logic signed [35:0]  c2_reg [2];
    logic signed [35:0]  c2_next [2];
    logic signed [35:0]  c3_reg [2];
    logic signed [35:0]  c3_next [2];
    logic signed [56:0]  prod_reg [2];
    logic signed [56:0]  prod_next [2];
    logic signed [39:0]  v_reg [2];
    logic signed [39:0]  v_next [2];
    logic signed [63:0]  fprod_reg, fprod_next;
    logic signed [31:0]  f_reg [3];
    logic signed [31:0]  f_next [3];

    logic signed [47:0]  esum_reg, esum_next;
    logic signed [47:0]  cx_reg, cx_next;
    logic signed [47:0]  cy_reg, cy_next;
    logic signed [47:0]  cz_reg, cz_next;

    logic                out_valid_reg, out_valid_next;
    logic [2:0]          ostat_reg, ostat_next;
    logic [15:0]         oidx_reg, oidx_next;
    logic signed [31:0]  ofx_reg, ofx_next;
    logic signed [31:0]  ofy_reg, ofy_next;
    logic signed [31:0]  ofz_reg, ofz_next;
    logic signed [47:0]  oe_reg, oe_next;
    logic signed [47:0]  ocx_reg, ocx_next;
    logic signed [47:0]  ocy_reg, ocy_next;
    logic signed [47:0]  ocz_reg, ocz_next;
    logic                olast_reg, olast_next;

    // table store ports
    logic                we_e;
    logic                we_d;
    logic [31:0]         wa_wide;
    logic                wa_in_range;
    logic [AW-1:0]       waddr;
    logic [31:0]         ra_wide;
    logic [AW-1:0]       raddr;
    logic [31:0]         rd_e;
    logic [31:0]         rd_d;

    // result emission
    logic                out_free;
    logic                emit;
    logic [2:0]          emit_status;
    logic [15:0]         emit_index;
    logic                emit_last;
    logic                emit_acc;
    logic signed [31:0]  fo [3];
    logic signed [39:0]  e_add;
    logic signed [47:0]  new_e;
    logic signed [47:0]  new_cx;
    logic signed [47:0]  new_cy;
    logic signed [47:0]  new_cz;

    logic [1:0]          pidx;
    logic signed [23:0]  dsel;
    logic signed [39:0]  step_ab;
    pt_pkg::coef_t       cf;

    // address generation
    always_comb
    begin
        wa_wide     = 32'(head.waddr);
        wa_in_range = (wa_wide < 32'(TDEPTH));
        waddr       = wa_wide[AW-1:0];
        ra_wide     = 32'(cur_reg.m) + 32'(cnt_reg) - 32'd1;
        raddr       = ra_wide[AW-1:0];
    end

    pt_ram #(
        .WIDTH (32),
        .DEPTH (TDEPTH)
    ) u_energy_ram (
        .clk   (clk),
        .we    (we_e),
        .waddr (waddr),
        .wdata (head.value),
        .raddr (raddr),
        .rdata (rd_e)
    );

    pt_ram #(
        .WIDTH (32),
        .DEPTH (TDEPTH)
    ) u_deriv_ram (
        .clk   (clk),
        .we    (we_d),
        .waddr (waddr),
        .wdata (head.value),
        .raddr (raddr),
        .rdata (rd_d)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pt_pkg::B_IDLE;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
            esum_reg      <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            cz_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            esum_reg      <= esum_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            cz_reg        <= cz_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        stat_reg  <= stat_next;
        acc_reg   <= acc_next;
        p_reg     <= p_next;
        c1_reg    <= c1_next;
        c2_reg    <= c2_next;
        c3_reg    <= c3_next;
        prod_reg  <= prod_next;
        v_reg     <= v_next;
        fprod_reg <= fprod_next;
        f_reg     <= f_next;
        ostat_reg <= ostat_next;
        oidx_reg  <= oidx_next;
        ofx_reg   <= ofx_next;
        ofy_reg   <= ofy_next;
        ofz_reg   <= ofz_next;
        oe_reg    <= oe_next;
        ocx_reg   <= ocx_next;
        ocy_reg   <= ocy_next;
        ocz_reg   <= ocz_next;
        olast_reg <= olast_next;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        cnt_next    = cnt_reg;
        stat_next   = stat_reg;
        acc_next    = acc_reg;
        p_next      = p_reg;
        c1_next     = c1_reg;
        c2_next     = c2_reg;
        c3_next     = c3_reg;
        prod_next   = prod_reg;
        v_next      = v_reg;
        fprod_next  = fprod_reg;
        f_next      = f_reg;
        pop         = 1'b0;
        we_e        = 1'b0;
        we_d        = 1'b0;
        emit        = 1'b0;
        emit_status = stat_reg;
        emit_index  = cur_reg.index;
        emit_last   = cur_reg.last;
        emit_acc    = acc_reg;
        out_free    = !out_valid_reg || !out_stall;
        pidx        = 2'(cnt_reg - 3'd1);
        dsel        = cur_reg.dx;
        step_ab     = '0;
        cf          = '0;

        case (state_reg)
            pt_pkg::B_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                    case (head.kind)
                        pt_pkg::KIND_WRITE_E:
                        begin
                            we_e        = wa_in_range;
                            emit        = 1'b1;
                            emit_status = head.status;
                            emit_index  = head.index;
                            emit_last   = head.last;
                            emit_acc    = 1'b0;
                        end
                        pt_pkg::KIND_WRITE_D:
                        begin
                            we_d        = wa_in_range;
                            emit        = 1'b1;
                            emit_status = head.status;
                            emit_index  = head.index;
                            emit_last   = head.last;
                            emit_acc    = 1'b0;
                        end
                        pt_pkg::KIND_APPLY:
                        begin
                            cnt_next   = 3'd0;
                            state_next = pt_pkg::B_READ;
                        end
                        default:
                        begin
                            emit        = 1'b1;
                            emit_status = head.status;
                            emit_index  = head.index;
                            emit_last   = head.last;
                            emit_acc    = 1'b0;
                        end
                    endcase
                end
            end

            pt_pkg::B_READ:
            begin
                // four words m-1..m+2 from each table, each read word stored in the step after its address
                if (cnt_reg != 3'd0)
                begin
                    p_next[0][pidx] = rd_e;
                    p_next[1][pidx] = rd_d;
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    state_next = pt_pkg::B_COEF;
                end
            end

            pt_pkg::B_COEF:
            begin
                if (p_reg[0][1] == 32'sd0)
                begin
                    stat_next  = pt_pkg::ST_ZERO_TABLE;
                    acc_next   = 1'b0;
                    state_next = pt_pkg::B_EMIT;
                end
                else
                begin
                    for (int l = 0; l < 2; l++)
                    begin
                        cf = pt_pkg::calc_coef(p_reg[l][0], p_reg[l][1],
                                               p_reg[l][2], p_reg[l][3]);
                        c1_next[l] = cf.c1;
                        c2_next[l] = cf.c2;
                        c3_next[l] = cf.c3;
                    end
                    state_next = pt_pkg::B_M1;
                end
            end

            pt_pkg::B_M1:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    prod_next[l] = $signed({1'b0, cur_reg.t}) * c3_reg[l];
                end
                state_next = pt_pkg::B_M2;
            end

            pt_pkg::B_M2:
            begin
                // a = c2 + t*c3/2^16, then t*a
                for (int l = 0; l < 2; l++)
                begin
                    step_ab      = c2_reg[l] + 40'(prod_reg[l] >>> 16);
                    prod_next[l] = $signed({1'b0, cur_reg.t}) * step_ab;
                end
                state_next = pt_pkg::B_M3;
            end

            pt_pkg::B_M3:
            begin
                // b = c1 + t*a/2^16, then t*b
                for (int l = 0; l < 2; l++)
                begin
                    step_ab      = c1_reg[l] + 40'(prod_reg[l] >>> 16);
                    prod_next[l] = $signed({1'b0, cur_reg.t}) * step_ab;
                end
                state_next = pt_pkg::B_V;
            end

            pt_pkg::B_V:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    v_next[l] = p_reg[l][1] + 40'(prod_reg[l] >>> 17);
                end
                cnt_next   = 3'd0;
                state_next = pt_pkg::B_FORCE;
            end

            pt_pkg::B_FORCE:
            begin
                // one component a cycle through a shared multiplier
                case (cnt_reg)
                    3'd0:    dsel = cur_reg.dx;
                    3'd1:    dsel = cur_reg.dy;
                    default: dsel = cur_reg.dz;
                endcase
                fprod_next = v_reg[1] * dsel;
                if (cnt_reg != 3'd0)
                begin
                    f_next[pidx] = pt_pkg::sat32(48'(fprod_reg >>> 16));
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                begin
                    stat_next  = pt_pkg::ST_APPLIED;
                    acc_next   = 1'b1;
                    state_next = pt_pkg::B_EMIT;
                end
            end

            pt_pkg::B_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = pt_pkg::B_IDLE;
                end
            end

            default:
            begin
                state_next = pt_pkg::B_IDLE;
            end
        endcase
    end

    // running sums and result register
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            fo[i] = emit_acc ? f_reg[i] : 32'sd0;
        end
        e_add  = emit_acc ? v_reg[0] : 40'sd0;
        new_e  = pt_pkg::sat48(50'(esum_reg) + 50'(e_add));
        new_cx = pt_pkg::sat48(50'(cx_reg) - 50'(fo[0]));
        new_cy = pt_pkg::sat48(50'(cy_reg) - 50'(fo[1]));
        new_cz = pt_pkg::sat48(50'(cz_reg) - 50'(fo[2]));

        out_valid_next = out_valid_reg;
        ostat_next     = ostat_reg;
        oidx_next      = oidx_reg;
        ofx_next       = ofx_reg;
        ofy_next       = ofy_reg;
        ofz_next       = ofz_reg;
        oe_next        = oe_reg;
        ocx_next       = ocx_reg;
        ocy_next       = ocy_reg;
        ocz_next       = ocz_reg;
        olast_next     = olast_reg;
        esum_next      = esum_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            ostat_next     = emit_status;
            oidx_next      = emit_index;
            ofx_next       = fo[0];
            ofy_next       = fo[1];
            ofz_next       = fo[2];
            oe_next        = new_e;
            ocx_next       = new_cx;
            ocy_next       = new_cy;
            ocz_next       = new_cz;
            olast_next     = emit_last;
            // totals clear after the last neighbour of a central atom
            esum_next      = emit_last ? 48'sd0 : new_e;
            cx_next        = emit_last ? 48'sd0 : new_cx;
            cy_next        = emit_last ? 48'sd0 : new_cy;
            cz_next        = emit_last ? 48'sd0 : new_cz;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = ostat_reg;
    assign result_index   = oidx_reg;
    assign force_x        = ofx_reg;
    assign force_y        = ofy_reg;
    assign force_z        = ofz_reg;
    assign energy_total   = oe_reg;
    assign center_force_x = ocx_reg;
    assign center_force_y = ocy_reg;
    assign center_force_z = ocz_reg;
    assign result_last    = olast_reg;

endmodule

`default_nettype wire

// ----- verif/tb_pair_table_cubic_force_core.sv -----
// ---------------------------------------------------------------------------
// tb_pair_table_cubic_force_core
// Self-checking bench for the tabulated pair force core: table loads and
// neighbour beats are predicted in order and every result beat is checked
// field by field, across several register settings and idle patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_pair_table_cubic_force_core;

    localparam int RES = 1024;
    localparam int DEPTH = RES + 5;
    localparam logic [1:0] FN_NONE = 2'd3;
    localparam longint MAX48 = 64'sd140737488355327;
    localparam longint MIN48 = -MAX48 - 1;

    typedef struct {
        logic [1:0]         fn;
        logic [10:0]        tidx;
        logic signed [31:0] tval;
        logic signed [23:0] dx;
        logic signed [23:0] dy;
        logic signed [23:0] dz;
        logic [7:0]         ntype;
        logic [15:0]        nidx;
        logic               last;
    } pair_beat_t;

    typedef struct {
        logic [2:0]         st;
        logic [15:0]        idx;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        logic signed [47:0] en;
        logic signed [47:0] cx;
        logic signed [47:0] cy;
        logic signed [47:0] cz;
        logic               last;
    } force_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [47:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] func = '0;
    logic [10:0] table_index = '0;
    logic signed [31:0] table_value = '0;
    logic signed [23:0] disp_x = '0;
    logic signed [23:0] disp_y = '0;
    logic signed [23:0] disp_z = '0;
    logic [7:0] neighbor_type = '0;
    logic [15:0] neighbor_index = '0;
    logic last_neighbor = 1'b0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic [2:0] status;
    logic [15:0] result_index;
    logic signed [31:0] force_x, force_y, force_z;
    logic signed [47:0] energy_total, center_force_x, center_force_y, center_force_z;
    logic result_last;

    pair_table_cubic_force_core #(.RES(RES)) i_dut (.*);

    // predictor state
    longint unsigned p_cutoff = 0, p_scale = 0;
    logic [7:0] p_partner = '0;
    logic p_match = 1'b0;
    int e_tab [DEPTH];
    int d_tab [DEPTH];
    bit e_set [DEPTH];
    bit d_set [DEPTH];
    longint sum_e = 0, sum_x = 0, sum_y = 0, sum_z = 0;

    pair_beat_t beats_to_send[$];
    force_result_t pending_results[$];
    int send_idle = 0, recv_idle = 0;
    int errors = 0, checked = 0, beats_sent = 0, phases = 0;
    int status_seen [8];
    bit hold_go = 1'b0, hold_seen = 1'b0;
    int hold_cnt = 0;

    initial forever #6 clk = ~clk;

    initial
    begin
        #20ms;
        $display("[pair_table_cubic_force_core] ERROR");
        $finish;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // filter stage: type, cutoff and radius range; m and t valid when applied
    function automatic logic [2:0] locate(pair_beat_t b, output int m, output longint t);
        longint x, y, z;
        longint unsigned rsq, q;
        x = b.dx;
        y = b.dy;
        z = b.dz;
        m = 0;
        t = 0;
        if (!p_match && b.ntype != p_partner)
            return pt_pkg::ST_TYPE_SKIP;
        rsq = x * x + y * y + z * z;
        if (rsq > p_cutoff)
            return pt_pkg::ST_BEYOND;
        q = (rsq >> 32) * p_scale + (((rsq & 64'hFFFF_FFFF) * p_scale) >> 32);
        if ((q >> 16) < 1 || (q >> 16) > RES)
            return pt_pkg::ST_BAD_RADIUS;
        m = int'(q >> 16);
        t = longint'(q & 64'hFFFF);
        return pt_pkg::ST_APPLIED;
    endfunction

    // four-point catmull-rom over either table
    function automatic longint cubic(bit deriv, int m, longint t);
        longint p0, p1, p2, p3, c1, c2, c3, a, b;
        p0 = deriv ? d_tab[m-1] : e_tab[m-1];
        p1 = deriv ? d_tab[m]   : e_tab[m];
        p2 = deriv ? d_tab[m+1] : e_tab[m+1];
        p3 = deriv ? d_tab[m+2] : e_tab[m+2];
        c1 = p2 - p0;
        c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c3 = 3 * (p1 - p2) + p3 - p0;
        a = c2 + ((t * c3) >>> 16);
        b = c1 + ((t * a) >>> 16);
        return p1 + ((t * b) >>> 17);
    endfunction

    // expected result of one beat, appended to the result queue; an unused function code yields none
    function automatic void predict_force(pair_beat_t b);
        force_result_t r;
        longint f [3];
        longint d [3];
        longint t, en, de;
        int m;
        if (b.fn == FN_NONE)
            return;
        f = '{0, 0, 0};
        if (b.fn == pt_pkg::FN_WRITE_E || b.fn == pt_pkg::FN_WRITE_D)
        begin
            if (b.tidx < DEPTH)
            begin
                if (b.fn == pt_pkg::FN_WRITE_E)
                begin
                    e_tab[b.tidx] = b.tval;
                    e_set[b.tidx] = 1'b1;
                end
                else
                begin
                    d_tab[b.tidx] = b.tval;
                    d_set[b.tidx] = 1'b1;
                end
            end
            r.st = pt_pkg::ST_WRITTEN;
            r.idx = {5'd0, b.tidx};
            r.last = 1'b0;
        end
        else
        begin
            d[0] = b.dx;
            d[1] = b.dy;
            d[2] = b.dz;
            r.st = locate(b, m, t);
            if (r.st == pt_pkg::ST_APPLIED && e_tab[m] == 0)
                r.st = pt_pkg::ST_ZERO_TABLE;
            else if (r.st == pt_pkg::ST_APPLIED)
            begin
                en = cubic(1'b0, m, t);
                de = cubic(1'b1, m, t);
                for (int i = 0; i < 3; i++)
                    f[i] = clamp((de * d[i]) >>> 16, -64'sd2147483648, 64'sd2147483647);
                sum_e = clamp(sum_e + en, MIN48, MAX48);
                sum_x = clamp(sum_x - f[0], MIN48, MAX48);
                sum_y = clamp(sum_y - f[1], MIN48, MAX48);
                sum_z = clamp(sum_z - f[2], MIN48, MAX48);
            end
            r.idx = b.nidx;
            r.last = b.last;
        end
        r.fx = 32'(f[0]);
        r.fy = 32'(f[1]);
        r.fz = 32'(f[2]);
        r.en = 48'(sum_e);
        r.cx = 48'(sum_x);
        r.cy = 48'(sum_y);
        r.cz = 48'(sum_z);
        pending_results.push_back(r);
        if (b.fn == pt_pkg::FN_NEIGHBOR && b.last)
        begin
            sum_e = 0;
            sum_x = 0;
            sum_y = 0;
            sum_z = 0;
        end
    endfunction

    function automatic void send(pair_beat_t b);
        beats_to_send.push_back(b);
        predict_force(b);
    endfunction

    function automatic logic signed [31:0] rand_word();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $signed($urandom_range(0, 2097152)) - 32'sd1048576;
    endfunction

    function automatic pair_beat_t junk_beat(logic [1:0] fn);
        pair_beat_t b;
        b.fn = fn;
        b.tidx = 11'($urandom_range(0, 2047));
        b.tval = $urandom;
        b.dx = 24'($urandom);
        b.dy = 24'($urandom);
        b.dz = 24'($urandom);
        b.ntype = 8'($urandom);
        b.nidx = 16'($urandom);
        b.last = 1'($urandom_range(0, 1));
        return b;
    endfunction

    // load a table word first if it was never written
    function automatic void load_word(bit deriv, int k, bit may_zero);
        pair_beat_t b;
        if (deriv ? d_set[k] : e_set[k])
            return;
        b = junk_beat(deriv ? pt_pkg::FN_WRITE_D : pt_pkg::FN_WRITE_E);
        b.tidx = 11'(k);
        b.tval = (may_zero && $urandom_range(0, 15) == 0) ? 32'sd0 : rand_word();
        send(b);
    endfunction

    // neighbour beat with every table word it will read loaded beforehand
    function automatic void send_neighbor(pair_beat_t b);
        int m;
        longint t;
        b.fn = pt_pkg::FN_NEIGHBOR;
        if (locate(b, m, t) == pt_pkg::ST_APPLIED)
        begin
            load_word(1'b0, m, 1'b1);
            if (e_tab[m] != 0)
                for (int k = m - 1; k <= m + 2; k++)
                begin
                    load_word(1'b0, k, 1'b0);
                    load_word(1'b1, k, 1'b0);
                end
        end
        send(b);
    endfunction

    function automatic pair_beat_t near_beat(int x, int y, int z, bit last);
        pair_beat_t b;
        b = junk_beat(pt_pkg::FN_NEIGHBOR);
        b.dx = 24'(x);
        b.dy = 24'(y);
        b.dz = 24'(z);
        b.ntype = p_partner;
        b.last = last;
        return b;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [47:0] v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            pt_pkg::CFG_CUTOFF:  p_cutoff = v;
            pt_pkg::CFG_SCALE:   p_scale = v[31:0];
            pt_pkg::CFG_PARTNER: p_partner = v[7:0];
            default:             p_match = v[0];
        endcase
    endtask

    task automatic set_regs(logic [47:0] cut, logic [31:0] scl, logic [7:0] ptype, bit any);
        write_reg(pt_pkg::CFG_CUTOFF, cut);
        write_reg(pt_pkg::CFG_SCALE, {16'd0, scl});
        write_reg(pt_pkg::CFG_PARTNER, {40'd0, ptype});
        write_reg(pt_pkg::CFG_MATCH, {47'd0, any});
        @(posedge clk);
        cfg_write <= 1'b0;
        phases++;
    endtask

    // sender pauses until nothing is outstanding, then lets the core settle
    task automatic drain();
        while (beats_to_send.size() != 0 || in_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_beats(int n);
        pair_beat_t b;
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 78)
            begin
                b = near_beat($urandom_range(0, 131072) - 65536,
                              $urandom_range(0, 131072) - 65536,
                              $urandom_range(0, 131072) - 65536,
                              $urandom_range(0, 11) == 0);
                if (p_match)
                    b.ntype = 8'($urandom);
                send_neighbor(b);
            end
            else if (sel < 88)
                send_neighbor(junk_beat(pt_pkg::FN_NEIGHBOR));
            else if (sel < 96)
                send(junk_beat($urandom_range(0, 1) ? pt_pkg::FN_WRITE_E : pt_pkg::FN_WRITE_D));
            else
            begin
                send(junk_beat(FN_NONE));
                i--;
            end
        end
    endtask

    // sender side
    always @(posedge clk)
    begin : drive_beats
        pair_beat_t b;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (beats_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle)
            begin
                b = beats_to_send.pop_front();
                func <= b.fn;
                table_index <= b.tidx;
                table_value <= b.tval;
                disp_x <= b.dx;
                disp_y <= b.dy;
                disp_z <= b.dz;
                neighbor_type <= b.ntype;
                neighbor_index <= b.nidx;
                last_neighbor <= b.last;
                in_valid <= 1'b1;
                beats_sent++;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver side, with one long hold-off on request
    always @(posedge clk)
    begin : drive_stall
        if (hold_go && !hold_seen)
        begin
            hold_seen <= 1'b1;
            hold_cnt <= 400;
            out_stall <= 1'b1;
        end
        else
        begin
            if (hold_cnt > 0)
                hold_cnt <= hold_cnt - 1;
            out_stall <= hold_cnt > 1 || $urandom_range(0, 99) < recv_idle;
        end
    end

    task automatic mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch %s at result %0d: got %0d want %0d", what, checked, got, want);
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        force_result_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                mismatch("unexpected beat", status, -1);
            else
            begin
                w = pending_results.pop_front();
                status_seen[status]++;
                if (status !== w.st) mismatch("status", status, w.st);
                if (result_index !== w.idx) mismatch("result_index", result_index, w.idx);
                if (force_x !== w.fx) mismatch("force_x", force_x, w.fx);
                if (force_y !== w.fy) mismatch("force_y", force_y, w.fy);
                if (force_z !== w.fz) mismatch("force_z", force_z, w.fz);
                if (energy_total !== w.en) mismatch("energy_total", energy_total, w.en);
                if (center_force_x !== w.cx) mismatch("center_force_x", center_force_x, w.cx);
                if (center_force_y !== w.cy) mismatch("center_force_y", center_force_y, w.cy);
                if (center_force_z !== w.cz) mismatch("center_force_z", center_force_z, w.cz);
                if (result_last !== w.last) mismatch("result_last", result_last, w.last);
            end
            checked++;
        end
    end

    initial
    begin : stimulus
        pair_beat_t b;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: m = floor(rsq * 85 / 2^32), cutoff just past the table end
        set_regs(48'd13 << 32, 32'd85 << 16, 8'd5, 1'b0);
        b = junk_beat(pt_pkg::FN_WRITE_E); b.tidx = 11'd0; b.tval = 32'sh7FFF_FFFF; send(b);
        b = junk_beat(pt_pkg::FN_WRITE_D); b.tidx = 11'd1028; b.tval = 32'sh8000_0000; send(b);
        b = junk_beat(pt_pkg::FN_WRITE_E); b.tidx = 11'd1029; send(b);
        b = junk_beat(pt_pkg::FN_WRITE_D); b.tidx = 11'd2047; send(b);
        b = junk_beat(pt_pkg::FN_WRITE_E); b.tidx = 11'd2; b.tval = 32'sd0; send(b);
        send(junk_beat(FN_NONE));
        // zero table at m = 2
        send_neighbor(near_beat(11240, 0, 0, 1'b0));
        // lowest and highest valid index
        send_neighbor(near_beat(8000, 0, 0, 1'b0));
        send_neighbor(near_beat(0, 0, 227530, 1'b0));
        send_neighbor(near_beat(0, -227530, 0, 1'b0));
        // radius zero and radius past the table
        send_neighbor(near_beat(0, 0, 0, 1'b0));
        send_neighbor(near_beat(-235274, 0, 0, 1'b0));
        // beyond cutoff at the field extremes
        send_neighbor(near_beat(8388607, -8388608, 8388607, 1'b0));
        // type skip, then the last neighbour clearing the totals
        b = near_beat(30000, 40000, 50000, 1'b0); b.ntype = 8'd6; send_neighbor(b);
        b = near_beat(-60000, 70000, -80000, 1'b1); send_neighbor(b);
        send_neighbor(near_beat(100000, -20000, 5000, 1'b1));
        drain();

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle = mode == 0 ? 29 : (mode == 1 ? 88 : 0);
            recv_idle = mode == 0 ? 88 : (mode == 1 ? 29 : 0);
            for (int k = 0; k < 2; k++)
            begin
                case (mode * 2 + k)
                    0: set_regs(48'd13 << 32, 32'd85 << 16, 8'd5, 1'b0);
                    1: set_regs(48'd0, 32'd0, 8'd0, 1'b0);
                    2: set_regs((48'd13 << 32) + $urandom, (32'd80 << 16) + $urandom_range(0, 655359),
                                8'hFF, 1'b1);
                    3: set_regs(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hA5, 1'b1);
                    4: set_regs(48'hFFFF_FFFF_FFFF, 32'd85 << 16, 8'hA5, 1'b0);
                    default: set_regs(48'd12 << 32, (32'd85 << 16) + $urandom_range(0, 65535),
                                      8'($urandom), 1'b0);
                endcase
                random_beats((k == 1 && mode < 2) ? 40 : 120);
                if (mode == 2 && k == 0)
                    hold_go = 1'b1;
                drain();
            end
        end

        $display("%0d beats sent over %0d register settings, %0d results checked",
                 beats_sent, phases, checked);
        $display("status counts applied %0d skip %0d beyond %0d zero %0d radius %0d written %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (errors == 0 && pending_results.size() == 0)
            $display("[pair_table_cubic_force_core] OK");
        else
            $display("[pair_table_cubic_force_core] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/pt_pkg.sv
rtl/core/pt_ram.sv
rtl/core/pt_front.sv
rtl/core/pt_queue.sv
rtl/core/pt_back.sv
rtl/core/pair_table_cubic_force_core.sv
verif/tb_pair_table_cubic_force_core.sv
